FILE: hw/rtl/ppp_pkg.sv
package ppp_pkg;

  // Fixed field widths of the stream payloads.
  localparam int FIELD_W = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int IN_W    = 328;
  localparam int OUT_W   = 72;

  // Internal arithmetic widths.
  localparam int ACC_W = 50;   // product sums before saturation
  localparam int UVW_W = 47;   // homogeneous image coordinates
  localparam int QP_W  = 34;   // quaternion products after the Q2.30 shift
  localparam int RS_W  = 37;   // rotation entries before saturation
  localparam int FRAC  = 16;

  localparam logic signed [RS_W-1:0] ONE_Q30 = 37'sd1073741824;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_ONE   = 2'd1,
    OP_ALL   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_SETUP  = 2'd1,
    ST_RANGE      = 2'd2,
    ST_ZERO_DEPTH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CAM_R0A = 3'd0,
    REG_CAM_R0B = 3'd1,
    REG_CAM_R1A = 3'd2,
    REG_CAM_R1B = 3'd3,
    REG_CAM_R2A = 3'd4,
    REG_CAM_R2B = 3'd5,
    REG_COUNT   = 3'd6,
    REG_SETUP   = 3'd7
  } reg_idx_t;

  // Where a finished product sum is written.
  typedef enum logic [1:0] {
    DST_Q = 2'd0,
    DST_M = 2'd1,
    DST_P = 2'd2
  } dst_t;

  typedef struct packed {
    logic                      vld;
    logic                      first;
    logic                      last;
    logic                      sh30;
    logic signed [FIELD_W-1:0] init;
    dst_t                      kind;
    logic [3:0]                idx;
  } mul_tag_t;

endpackage

FILE: hw/rtl/ppp_div.sv
module ppp_div import ppp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [UVW_W-1:0]   num_x,
  input  logic signed [UVW_W-1:0]   num_y,
  input  logic signed [UVW_W-1:0]   den,
  output logic                      done,
  output logic signed [FIELD_W-1:0] quo_x,
  output logic signed [FIELD_W-1:0] quo_y
);

  // Quotient bits worked out; anything above that saturates anyway.
  localparam int QB = FIELD_W + 1;
  localparam int DW = UVW_W + FRAC;

  logic                 busy;
  logic [5:0]           cnt;
  logic [UVW_W-1:0]     dmag;
  logic [UVW_W-1:0]     rem  [2];
  logic [QB-1:0]        dlo  [2];
  logic [QB-1:0]        quo  [2];
  logic                 ovf  [2];
  logic                 neg  [2];
  logic signed [UVW_W-1:0] num [2];
  logic [UVW_W-1:0]     nmag [2];
  logic [DW-1:0]        dvd  [2];
  logic [UVW_W:0]       r2   [2];
  logic [UVW_W:0]       r2d  [2];
  logic signed [FIELD_W-1:0] res [2];
  logic [UVW_W-1:0]     dmag_in;

  assign num[0]  = num_x;
  assign num[1]  = num_y;
  assign dmag_in = den[UVW_W-1] ? UVW_W'(-den) : UVW_W'(den);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nmag[l] = num[l][UVW_W-1] ? UVW_W'(-num[l]) : UVW_W'(num[l]);
      dvd[l]  = {nmag[l], FRAC'(0)};
      r2[l]   = {rem[l], dlo[l][QB-1]};
      r2d[l]  = r2[l] - {1'b0, dmag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dmag <= dmag_in;
      for (int l = 0; l < 2; l++) begin
        rem[l] <= UVW_W'(dvd[l][DW-1:QB]);
        dlo[l] <= dvd[l][QB-1:0];
        quo[l] <= '0;
        ovf[l] <= UVW_W'(dvd[l][DW-1:QB]) >= dmag_in;
        neg[l] <= num[l][UVW_W-1] ^ den[UVW_W-1];
      end
    end else if (busy) begin
      for (int l = 0; l < 2; l++) begin
        dlo[l] <= {dlo[l][QB-2:0], 1'b0};
        if (!r2d[l][UVW_W]) begin
          rem[l] <= r2d[l][UVW_W-1:0];
          quo[l] <= {quo[l][QB-2:0], 1'b1};
        end else begin
          rem[l] <= r2[l][UVW_W-1:0];
          quo[l] <= {quo[l][QB-2:0], 1'b0};
        end
      end
    end
  end

  // Sign and saturation of the unsigned quotient.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg[l]) begin
        if (ovf[l] || quo[l] > QB'(33'h080000000)) begin
          res[l] = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
          res[l] = FIELD_W'(-quo[l]);
        end
      end else begin
        if (ovf[l] || quo[l] > QB'(33'h07fffffff)) begin
          res[l] = {1'b0, {(FIELD_W-1){1'b1}}};
        end else begin
          res[l] = FIELD_W'(quo[l]);
        end
      end
    end
  end

  assign quo_x = res[0];
  assign quo_y = res[1];

endmodule

FILE: hw/rtl/pinhole_point_projector.sv
// Channel     | Dir | Carries
// s_axis      | in  | one command transaction: write a point, project one, project all
// m_axis      | out | one projected point per transaction, tlast on the final one
// cfg         | in  | register write: cfg_we, cfg_index, cfg_data
//
// One 32x32 multiplier does every product and one two-lane restoring divider does
// the perspective division. A projection first builds the full matrix (9 + 36
// products), then handles each point with 9 products, 33 divider steps, a read and
// a hand-off. The input is not ready until the last result transaction has been
// taken; a stalled output holds the sequencer. Reset is synchronous and clears
// control state and registers; the point table is not cleared.
module pinhole_point_projector import ppp_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // operation, point_index, point_x, point_y, point_z, pose_pos_x, pose_pos_y,
  // pose_pos_z, quat_w, quat_x, quat_y, quat_z
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // result_index, image_x, image_y, status
  output logic [OUT_W-1:0]  m_axis_tdata,
  output logic              m_axis_tlast,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam int SW      = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int Q_TERMS = 9;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_QMUL = 9'b000000010,
    S_RBLD = 9'b000000100,
    S_MMUL = 9'b000001000,
    S_PRD  = 9'b000010000,
    S_PMUL = 9'b000100000,
    S_WCHK = 9'b001000000,
    S_DIVW = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:FIELD_W-1] != {(ACC_W-FIELD_W+1){v[ACC_W-1]}}) begin
      return v[ACC_W-1] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return v[FIELD_W-1:0];
  endfunction

  function automatic logic signed [UVW_W-1:0] sat47(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:UVW_W-1] != {(ACC_W-UVW_W+1){v[ACC_W-1]}}) begin
      return v[ACC_W-1] ? {1'b1, {(UVW_W-1){1'b0}}} : {1'b0, {(UVW_W-1){1'b1}}};
    end
    return v[UVW_W-1:0];
  endfunction

  function automatic logic signed [FIELD_W-1:0] satr(input logic signed [RS_W-1:0] v);
    if (v[RS_W-1:FIELD_W-1] != {(RS_W-FIELD_W+1){v[RS_W-1]}}) begin
      return v[RS_W-1] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return v[FIELD_W-1:0];
  endfunction

  // Input fields.
  op_t                       in_op;
  logic [IDX_W-1:0]          in_idx;
  logic [FIELD_W-1:0]        in_px, in_py, in_pz;
  logic signed [FIELD_W-1:0] in_tx, in_ty, in_tz, in_qw, in_qx, in_qy, in_qz;
  logic                      in_acc;

  assign in_op  = op_t'(s_axis_tdata[1:0]);
  assign in_idx = s_axis_tdata[7:2];
  assign in_px  = s_axis_tdata[39:8];
  assign in_py  = s_axis_tdata[71:40];
  assign in_pz  = s_axis_tdata[103:72];
  assign in_tx  = s_axis_tdata[135:104];
  assign in_ty  = s_axis_tdata[167:136];
  assign in_tz  = s_axis_tdata[199:168];
  assign in_qw  = s_axis_tdata[231:200];
  assign in_qx  = s_axis_tdata[263:232];
  assign in_qy  = s_axis_tdata[295:264];
  assign in_qz  = s_axis_tdata[327:296];

  // Configuration registers.
  logic [63:0]      cam [6];
  logic [CNT_W-1:0] point_count;
  logic             setup_done;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        cam[i] <= '0;
      end
      point_count <= '0;
      setup_done  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAM_R0A: cam[0] <= cfg_data;
        REG_CAM_R0B: cam[1] <= cfg_data;
        REG_CAM_R1A: cam[2] <= cfg_data;
        REG_CAM_R1B: cam[3] <= cfg_data;
        REG_CAM_R2A: cam[4] <= cfg_data;
        REG_CAM_R2B: cam[5] <= cfg_data;
        REG_COUNT:   point_count <= cfg_data[CNT_W-1:0];
        REG_SETUP:   setup_done <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign count = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;

  logic signed [FIELD_W-1:0] cam_rc [3][3];
  logic signed [FIELD_W-1:0] cam_t  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cam_rc[r][c] = cam[r*2 + (c >> 1)][(c & 1)*FIELD_W +: FIELD_W];
      end
      cam_t[r] = cam[r*2 + 1][FIELD_W +: FIELD_W];
    end
  end

  // Sequencer state.
  state_t           state;
  logic [3:0]       qcnt;
  logic [1:0]       ci, cj, ck;
  logic             iss_done;
  logic             all_mode;
  logic [IDX_W-1:0] pidx;

  // Output register.
  logic                      out_valid;
  logic [IDX_W-1:0]          out_idx;
  logic signed [FIELD_W-1:0] out_x, out_y;
  status_t                   out_status;
  logic                      out_last;

  // Latched pose.
  logic signed [FIELD_W-1:0] qw, qx, qy, qz;
  logic signed [FIELD_W-1:0] t_reg [3];

  // Point table.
  logic [3*SW-1:0]        mem [MAX_POINTS];
  logic [3*SW-1:0]        mem_q;
  logic                   wr_en, rd_en;
  logic signed [SW-1:0]   p_raw [3];
  logic signed [FIELD_W-1:0] p_ext [3];

  // Arithmetic results.
  logic signed [QP_W-1:0]    q_prod [Q_TERMS];
  logic signed [FIELD_W-1:0] r_mat  [3][3];
  logic signed [FIELD_W-1:0] m_rot  [3][3];
  logic signed [FIELD_W-1:0] m_trn  [3];
  logic signed [UVW_W-1:0]   uvw    [3];

  // Multiplier pipeline.
  logic signed [FIELD_W-1:0]   mul_a, mul_b;
  mul_tag_t                    tag_a, tag_b;
  logic signed [2*FIELD_W-1:0] prod;
  logic signed [ACC_W-1:0]     acc, acc_next, shifted, base;

  logic                      div_start, div_done;
  logic signed [FIELD_W-1:0] quo_x, quo_y;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign wr_en         = in_acc && (in_op == OP_WRITE) &&
                         ({1'b0, in_idx} < CNT_W'(MAX_POINTS));
  assign rd_en         = (state == S_PRD);
  assign div_start     = (state == S_WCHK) && (uvw[2] != '0);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      qw       <= in_qw;
      qx       <= in_qx;
      qy       <= in_qy;
      qz       <= in_qz;
      t_reg[0] <= in_tx;
      t_reg[1] <= in_ty;
      t_reg[2] <= in_tz;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_idx[AW-1:0]] <= {in_pz[SW-1:0], in_py[SW-1:0], in_px[SW-1:0]};
    end
    if (rd_en) begin
      mem_q <= mem[pidx[AW-1:0]];
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p_raw[j] = mem_q[j*SW +: SW];
      p_ext[j] = FIELD_W'(p_raw[j]);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    tag_a = '0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_QMUL: begin
        if (qcnt < 4'(Q_TERMS)) begin
          tag_a.vld   = 1'b1;
          tag_a.first = 1'b1;
          tag_a.last  = 1'b1;
          tag_a.sh30  = 1'b1;
          tag_a.kind  = DST_Q;
          tag_a.idx   = qcnt;
          case (qcnt)
            4'd0:    begin mul_a = qx; mul_b = qx; end
            4'd1:    begin mul_a = qy; mul_b = qy; end
            4'd2:    begin mul_a = qz; mul_b = qz; end
            4'd3:    begin mul_a = qx; mul_b = qy; end
            4'd4:    begin mul_a = qx; mul_b = qz; end
            4'd5:    begin mul_a = qy; mul_b = qz; end
            4'd6:    begin mul_a = qw; mul_b = qx; end
            4'd7:    begin mul_a = qw; mul_b = qy; end
            default: begin mul_a = qw; mul_b = qz; end
          endcase
        end
      end
      S_MMUL: begin
        if (!iss_done) begin
          tag_a.vld   = 1'b1;
          tag_a.first = (ck == 2'd0);
          tag_a.last  = (ck == 2'd2);
          tag_a.sh30  = (cj != 2'd3);
          tag_a.init  = (cj == 2'd3) ? cam_t[ci] : '0;
          tag_a.kind  = DST_M;
          tag_a.idx   = {ci, cj};
          mul_a       = cam_rc[ci][ck];
          mul_b       = (cj == 2'd3) ? t_reg[ck] : r_mat[ck][cj];
        end
      end
      S_PMUL: begin
        if (!iss_done) begin
          tag_a.vld   = 1'b1;
          tag_a.first = (ck == 2'd0);
          tag_a.last  = (ck == 2'd2);
          tag_a.init  = m_trn[ci];
          tag_a.kind  = DST_P;
          tag_a.idx   = {2'b00, ci};
          mul_a       = m_rot[ci][ck];
          mul_b       = p_ext[ck];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_b <= '0;
    end else begin
      tag_b <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign shifted  = tag_b.sh30 ? ACC_W'(prod >>> 30) : ACC_W'(prod >>> FRAC);
  assign base     = tag_b.first ? ACC_W'(tag_b.init) : acc;
  assign acc_next = base + shifted;

  always_ff @(posedge clk) begin
    if (tag_b.vld) begin
      acc <= acc_next;
      if (tag_b.last) begin
        case (tag_b.kind)
          DST_Q: q_prod[tag_b.idx] <= acc_next[QP_W-1:0];
          DST_M: begin
            if (tag_b.idx[1:0] == 2'd3) begin
              m_trn[tag_b.idx[3:2]] <= sat32(acc_next);
            end else begin
              m_rot[tag_b.idx[3:2]][tag_b.idx[1:0]] <= sat32(acc_next);
            end
          end
          DST_P: uvw[tag_b.idx[1:0]] <= sat47(acc_next);
          default: ;
        endcase
      end
    end
  end

  // Rotation matrix from the quaternion products.
  logic signed [RS_W-1:0] qe [Q_TERMS];

  always_comb begin
    for (int k = 0; k < Q_TERMS; k++) begin
      qe[k] = RS_W'(q_prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RBLD) begin
      r_mat[0][0] <= satr(ONE_Q30 - ((qe[1] + qe[2]) <<< 1));
      r_mat[0][1] <= satr((qe[3] - qe[8]) <<< 1);
      r_mat[0][2] <= satr((qe[4] + qe[7]) <<< 1);
      r_mat[1][0] <= satr((qe[3] + qe[8]) <<< 1);
      r_mat[1][1] <= satr(ONE_Q30 - ((qe[0] + qe[2]) <<< 1));
      r_mat[1][2] <= satr((qe[5] - qe[6]) <<< 1);
      r_mat[2][0] <= satr((qe[4] - qe[7]) <<< 1);
      r_mat[2][1] <= satr((qe[5] + qe[6]) <<< 1);
      r_mat[2][2] <= satr(ONE_Q30 - ((qe[0] + qe[1]) <<< 1));
    end
  end

  ppp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_x (uvw[0]),
    .num_y (uvw[1]),
    .den   (uvw[2]),
    .done  (div_done),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      iss_done  <= 1'b0;
      qcnt      <= '0;
      ci        <= '0;
      cj        <= '0;
      ck        <= '0;
      all_mode  <= 1'b0;
      pidx      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && (in_op == OP_ONE || in_op == OP_ALL)) begin
            if (!setup_done) begin
              out_idx    <= (in_op == OP_ONE) ? in_idx : '0;
              out_x      <= '0;
              out_y      <= '0;
              out_status <= ST_NOT_SETUP;
              out_last   <= 1'b1;
              out_valid  <= 1'b1;
              all_mode   <= 1'b0;
              state      <= S_OUT;
            end else if (in_op == OP_ONE && {1'b0, in_idx} >= count) begin
              out_idx    <= in_idx;
              out_x      <= '0;
              out_y      <= '0;
              out_status <= ST_RANGE;
              out_last   <= 1'b1;
              out_valid  <= 1'b1;
              all_mode   <= 1'b0;
              state      <= S_OUT;
            end else if (!(in_op == OP_ALL && count == '0)) begin
              pidx     <= (in_op == OP_ONE) ? in_idx : '0;
              all_mode <= (in_op == OP_ALL);
              qcnt     <= '0;
              state    <= S_QMUL;
            end
          end
        end
        S_QMUL: begin
          if (qcnt == 4'(Q_TERMS)) begin
            state <= S_RBLD;
          end else begin
            qcnt <= qcnt + 4'd1;
          end
        end
        S_RBLD: begin
          ci       <= '0;
          cj       <= '0;
          ck       <= '0;
          iss_done <= 1'b0;
          state    <= S_MMUL;
        end
        S_MMUL: begin
          if (iss_done) begin
            iss_done <= 1'b0;
            state    <= S_PRD;
          end else if (ck == 2'd2) begin
            ck <= '0;
            if (cj == 2'd3) begin
              cj <= '0;
              if (ci == 2'd2) begin
                iss_done <= 1'b1;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              cj <= cj + 2'd1;
            end
          end else begin
            ck <= ck + 2'd1;
          end
        end
        S_PRD: begin
          ci       <= '0;
          ck       <= '0;
          iss_done <= 1'b0;
          state    <= S_PMUL;
        end
        S_PMUL: begin
          if (iss_done) begin
            iss_done <= 1'b0;
            state    <= S_WCHK;
          end else if (ck == 2'd2) begin
            ck <= '0;
            if (ci == 2'd2) begin
              iss_done <= 1'b1;
            end else begin
              ci <= ci + 2'd1;
            end
          end else begin
            ck <= ck + 2'd1;
          end
        end
        S_WCHK: begin
          out_idx  <= pidx;
          out_last <= all_mode ? (({1'b0, pidx} + CNT_W'(1)) == count) : 1'b1;
          if (uvw[2] == '0) begin
            out_x      <= '0;
            out_y      <= '0;
            out_status <= ST_ZERO_DEPTH;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            out_x      <= quo_x;
            out_y      <= quo_y;
            out_status <= ST_OK;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (all_mode && !out_last) begin
              pidx  <= pidx + IDX_W'(1);
              state <= S_PRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_status, out_y, out_x, out_idx};
  assign m_axis_tlast  = out_last;

  // The block never takes a command while a result transaction is pending.
  a_busy_when_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("command accepted while a result is pending");

  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[71:70] == ST_ZERO_DEPTH) |->
      (m_axis_tdata[37:6] == '0 && m_axis_tdata[69:38] == '0))
    else $error("zero depth result carries a nonzero image position");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[71:70] == ST_NOT_SETUP ||
                       m_axis_tdata[71:70] == ST_RANGE)) |-> m_axis_tlast)
    else $error("error result not marked last");

endmodule
